// ----- design/xcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// XOR checked frame deframer package
// Shared constants and types for the frame deframer.
// ----------------------------------------------------------------------------
package xcfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 3;

  localparam logic [ByteW-1:0] StartByte = 8'hFF;
  localparam logic [ByteW-1:0] MaxLenReset = 8'd100;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_ACCEPTED = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_EMPTY    = 3'd3,
    KIND_TOO_LONG = 3'd4
  } kind_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
  } result_t;

endpackage

// ----- design/xor_checked_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// XOR checked frame deframer
// An accepted byte waits in the input register and its result is registered
// into the result register when that has space. Throughput is one byte per
// cycle unless the receiver stalls, set by the single parser pass between them.
// Reset clears the frame state and sets the maximum payload length to 100.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [xcfd_pkg::ByteW-1:0] rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [xcfd_pkg::KindW-1:0] kind_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [xcfd_pkg::ByteW-1:0] max_payload_length_i
);

  logic                       stage_valid;
  logic [xcfd_pkg::ByteW-1:0] stage_byte;
  logic                       space;
  logic                       advance;
  xcfd_pkg::result_t          result;

  assign cfg_ready_o = 1'b1;
  assign advance     = stage_valid && space;

  xcfd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .in_stall_o (in_stall_o),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  xcfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_write_i   (cfg_valid_i && cfg_ready_o),
    .cfg_max_len_i (max_payload_length_i),
    .step_i        (advance),
    .byte_i        (stage_byte),
    .result_o      (result)
  );

  xcfd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o)
  );

endmodule

// ----- design/xcfd_in_stage.sv -----
// ----------------------------------------------------------------------------
// Input register
// Holds one received byte until the parser can take it.
// ----------------------------------------------------------------------------
module xcfd_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [xcfd_pkg::ByteW-1:0] rx_byte_i,
  output logic                       in_stall_o,
  input  logic                       advance_i,
  output logic                       valid_o,
  output logic [xcfd_pkg::ByteW-1:0] byte_o
);

  logic                       valid_d, valid_q;
  logic [xcfd_pkg::ByteW-1:0] byte_d, byte_q;
  logic                       accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = in_stall_o ? valid_q : in_valid_i;
    byte_d  = accept ? rx_byte_i : byte_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ----- design/xcfd_parser.sv -----
// ----------------------------------------------------------------------------
// Frame parser
// Tracks the frame phase, payload count and running XOR, and decides the
// result of each byte.
// ----------------------------------------------------------------------------
module xcfd_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_write_i,
  input  logic [xcfd_pkg::ByteW-1:0] cfg_max_len_i,
  input  logic                       step_i,
  input  logic [xcfd_pkg::ByteW-1:0] byte_i,
  output xcfd_pkg::result_t          result_o
);

  localparam logic [1:0] PhaseHunt    = 2'd0;
  localparam logic [1:0] PhaseLength  = 2'd1;
  localparam logic [1:0] PhasePayload = 2'd2;
  localparam logic [1:0] PhaseCheck   = 2'd3;

  logic [1:0]                 phase_d, phase_q;
  logic [xcfd_pkg::ByteW-1:0] len_d, len_q;
  logic [xcfd_pkg::ByteW-1:0] pos_d, pos_q;
  logic [xcfd_pkg::ByteW-1:0] xor_d, xor_q;
  logic [xcfd_pkg::ByteW-1:0] max_len_d, max_len_q;
  logic [xcfd_pkg::ByteW-1:0] pos_inc;

  assign pos_inc = pos_q + 8'd1;
  assign max_len_d = cfg_write_i ? cfg_max_len_i : max_len_q;

  always_comb begin
    phase_d         = phase_q;
    len_d           = len_q;
    pos_d           = pos_q;
    xor_d           = xor_q;
    result_o.valid  = 1'b0;
    result_o.kind   = xcfd_pkg::KIND_PAYLOAD;
    if (step_i) begin
      unique case (phase_q)
        PhaseHunt: begin
          if (byte_i == xcfd_pkg::StartByte) begin
            xor_d   = xcfd_pkg::StartByte;
            phase_d = PhaseLength;
          end
        end
        PhaseLength: begin
          if (byte_i == '0) begin
            phase_d        = PhaseHunt;
            result_o.valid = 1'b1;
            result_o.kind  = xcfd_pkg::KIND_EMPTY;
          end else if (byte_i > max_len_q) begin
            phase_d        = PhaseHunt;
            result_o.valid = 1'b1;
            result_o.kind  = xcfd_pkg::KIND_TOO_LONG;
          end else begin
            len_d   = byte_i;
            pos_d   = '0;
            xor_d   = xor_q ^ byte_i;
            phase_d = PhasePayload;
          end
        end
        PhasePayload: begin
          xor_d          = xor_q ^ byte_i;
          pos_d          = pos_inc;
          if (pos_inc >= len_q) begin
            phase_d = PhaseCheck;
          end
          result_o.valid = 1'b1;
          result_o.kind  = xcfd_pkg::KIND_PAYLOAD;
        end
        default: begin
          phase_d        = PhaseHunt;
          result_o.valid = 1'b1;
          result_o.kind  = (byte_i == xor_q) ? xcfd_pkg::KIND_ACCEPTED
                                             : xcfd_pkg::KIND_MISMATCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhaseHunt;
      len_q     <= '0;
      pos_q     <= '0;
      xor_q     <= '0;
      max_len_q <= xcfd_pkg::MaxLenReset;
    end else begin
      phase_q   <= phase_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      xor_q     <= xor_d;
      max_len_q <= max_len_d;
    end
  end

endmodule

// ----- design/xcfd_out_stage.sv -----
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module xcfd_out_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  xcfd_pkg::result_t          result_i,
  output logic                       space_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [xcfd_pkg::KindW-1:0] kind_o
);

  logic                       valid_d, valid_q;
  logic [xcfd_pkg::KindW-1:0] kind_d, kind_q;

  assign space_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = space_o ? result_i.valid : valid_q;
    kind_d  = (space_o && result_i.valid) ? result_i.kind : kind_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;

endmodule

// ----- test/xcfd_checker.sv -----
// ----------------------------------------------------------------------------
// XOR checked frame deframer checker
// Watches the byte, result and configuration channels of the deframer. It
// keeps its own copy of the frame parser and the maximum payload length,
// queues the expected kind for every accepted byte that yields a result, and
// compares each accepted result with the oldest queued kind.
// ----------------------------------------------------------------------------
module xcfd_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [xcfd_pkg::ByteW-1:0] rx_byte_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [xcfd_pkg::KindW-1:0] kind_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [xcfd_pkg::ByteW-1:0] max_len_i,
  output int unsigned                err_count_o,
  output int unsigned                pending_o,
  output int unsigned                checked_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECK
  } parse_phase_e;

  parse_phase_e               phase_q;
  logic [xcfd_pkg::ByteW-1:0] frame_len_q;
  logic [xcfd_pkg::ByteW-1:0] pos_q;
  logic [xcfd_pkg::ByteW-1:0] xor_q;
  logic [xcfd_pkg::ByteW-1:0] max_len_q;
  xcfd_pkg::kind_e            pending_kinds[$];
  int unsigned                errors;
  int unsigned                checked;

  task automatic deframe_byte(input logic [xcfd_pkg::ByteW-1:0] b);
    case (phase_q)
      PH_HUNT: begin
        if (b == xcfd_pkg::StartByte) begin
          xor_q   = xcfd_pkg::StartByte;
          phase_q = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (b == '0) begin
          phase_q = PH_HUNT;
          pending_kinds.push_back(xcfd_pkg::KIND_EMPTY);
        end else if (b > max_len_q) begin
          phase_q = PH_HUNT;
          pending_kinds.push_back(xcfd_pkg::KIND_TOO_LONG);
        end else begin
          frame_len_q = b;
          pos_q       = '0;
          xor_q       = xor_q ^ b;
          phase_q     = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        xor_q = xor_q ^ b;
        pos_q = pos_q + 1'b1;
        if (pos_q >= frame_len_q) begin
          phase_q = PH_CHECK;
        end
        pending_kinds.push_back(xcfd_pkg::KIND_PAYLOAD);
      end
      default: begin
        phase_q = PH_HUNT;
        pending_kinds.push_back((b == xor_q) ? xcfd_pkg::KIND_ACCEPTED
                                             : xcfd_pkg::KIND_MISMATCH);
      end
    endcase
  endtask

  task automatic note_error(input string what, input int want, input int got);
    errors++;
    if (errors <= 10) begin
      $display("[%0t] %s: expected kind %0d, got kind %0d", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : p_track
    xcfd_pkg::kind_e want;
    if (!rst_ni) begin
      phase_q     = PH_HUNT;
      frame_len_q = '0;
      pos_q       = '0;
      xor_q       = '0;
      max_len_q   = xcfd_pkg::MaxLenReset;
      errors      = 0;
      checked     = 0;
      pending_kinds.delete();
      err_count_o <= 0;
      pending_o   <= 0;
      checked_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_kinds.size() == 0) begin
          note_error("Unexpected result", -1, int'(kind_i));
        end else begin
          want = pending_kinds.pop_front();
          checked++;
          if (kind_i !== want) begin
            note_error("Kind mismatch", int'(want), int'(kind_i));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        max_len_q = max_len_i;
      end
      if (in_valid_i && !in_stall_i) begin
        deframe_byte(rx_byte_i);
      end
      err_count_o <= errors;
      pending_o   <= pending_kinds.size();
      checked_o   <= checked;
    end
  end

endmodule

// ----- test/tb_xor_checked_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// XOR checked frame deframer testbench
// Feeds directed byte sequences and then random frames (good, corrupted,
// empty, too long and cut short, with noise between them) under several
// maximum payload lengths, with bursty requests and a stalling receiver.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_xor_checked_frame_deframer;

  localparam int PhaseBytes = 160;
  localparam int NumPhases  = 6;
  localparam int HoldCycles = 100;
  localparam int SettleCycles = 4;
  localparam int CycleLimit = 200000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [xcfd_pkg::ByteW-1:0] rx_byte_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [xcfd_pkg::KindW-1:0] kind_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [xcfd_pkg::ByteW-1:0] max_payload_length_i = '0;

  int unsigned      err_count;
  int unsigned      pending;
  int unsigned      checked;

  logic [xcfd_pkg::ByteW-1:0] cur_max = xcfd_pkg::MaxLenReset;
  int               hold_asked = 0;
  int               fed_bytes = 0;
  int               burst_left = 0;
  int               cycle_count = 0;

  always #10 clk_i = ~clk_i;

  xor_checked_frame_deframer dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .kind_o              (kind_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .max_payload_length_i(max_payload_length_i)
  );

  xcfd_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_i (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_i(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_i     (kind_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_i(cfg_ready_o),
    .max_len_i  (max_payload_length_i),
    .err_count_o(err_count),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  task automatic push_byte(input logic [xcfd_pkg::ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_frame(input int len, input int cut, input bit corrupt);
    logic [xcfd_pkg::ByteW-1:0] sum;
    logic [xcfd_pkg::ByteW-1:0] b;
    int                         n;
    sum = xcfd_pkg::StartByte ^ 8'(len);
    push_byte(xcfd_pkg::StartByte);
    push_byte(8'(len));
    fed_bytes += 2;
    if (len != 0 && len <= int'(cur_max)) begin
      n = (cut >= 0 && cut < len) ? cut : len;
      for (int i = 0; i < n; i++) begin
        b   = 8'($urandom);
        sum = sum ^ b;
        push_byte(b);
      end
      fed_bytes += n;
      if (n == len) begin
        push_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
        fed_bytes++;
      end
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 30);
    if (r < 94) return (cur_max < 8'd255) ? int'(cur_max) + 1 : $urandom_range(31, 60);
    if (r == 94) return int'(cur_max);
    return $urandom_range(31, 255);
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [xcfd_pkg::ByteW-1:0] v);
    cfg_valid_i          <= 1'b1;
    max_payload_length_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_max = v;
  endtask

  initial begin : p_receiver
    int served;
    int mode;
    int tick;
    served = 0;
    tick   = 0;
    forever begin
      if (hold_asked != served) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        served++;
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(8, 60)) begin
          tick++;
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= ($urandom_range(0, 99) < 30);
            2:       out_stall_i <= (tick % 4 == 3);
            default: out_stall_i <= ($urandom_range(0, 99) < 70);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : p_watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : p_stimulus
    int r;
    int len;
    int goal;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequences at the reset maximum of 100.
    push_byte(8'h00);
    push_byte(8'h7E);
    send_frame(0, -1, 1'b0);
    send_frame(101, -1, 1'b0);
    push_byte(xcfd_pkg::StartByte);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'hFE);
    push_byte(xcfd_pkg::StartByte);
    push_byte(8'h02);
    push_byte(xcfd_pkg::StartByte);
    push_byte(8'h00);
    push_byte(8'h03);
    push_byte(xcfd_pkg::StartByte);
    push_byte(xcfd_pkg::StartByte);
    drain_results();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       write_max_len(8'd0);
        1:       write_max_len(8'd255);
        2:       write_max_len(8'd1);
        4:       write_max_len(xcfd_pkg::MaxLenReset);
        default: write_max_len(8'($urandom_range(2, 254)));
      endcase
      if (p == 0) begin
        send_frame(1, -1, 1'b0);
        send_frame(0, -1, 1'b0);
      end
      if (p == 1) begin
        hold_asked++;
        send_frame(40, -1, 1'b0);
      end
      goal = fed_bytes + PhaseBytes;
      while (fed_bytes < goal) begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          send_frame(pick_len(), -1, 1'b0);
        end else if (r < 75) begin
          send_frame(pick_len(), -1, 1'b1);
        end else if (r < 83) begin
          send_frame(0, -1, 1'b0);
        end else if (r < 90) begin
          len = pick_len();
          send_frame(len, $urandom_range(0, len - 1), 1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 254)));
        end
        if (p == 3 && fed_bytes >= goal - PhaseBytes / 2 && fed_bytes < goal - PhaseBytes / 2 + 8
            || $urandom_range(0, 99) < 2) begin
          drain_results();
        end
      end
      drain_results();
    end

    $display("Fed %0d frame bytes and checked %0d results over %0d length settings",
             fed_bytes, checked, NumPhases + 1);
    $display("Limits covered 0, 1, 100, 255 and random values, with a long receiver hold.");
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/xcfd_pkg.sv
design/xcfd_in_stage.sv
design/xcfd_parser.sv
design/xcfd_out_stage.sv
design/xor_checked_frame_deframer.sv
test/xcfd_checker.sv
test/tb_xor_checked_frame_deframer.sv
